>>> rtl/core/ami_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ami_pkg
// Shared types and constants of the affine matrix inverse pipeline.
// ----------------------------------------------------------------------------
package ami_pkg;

    localparam int DATA_W  = 32;
    localparam int PROD_W  = 64;
    localparam int COF_W   = 65;
    localparam int CMAG_W  = 64;
    localparam int DET_W   = 98;
    localparam int DMAG_W  = 97;
    localparam int D2_W    = 98;
    localparam int TSUM_W  = 67;
    localparam int LANES   = 9;
    localparam int FLOOR_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [FLOOR_W-1:0] DET_FLOOR_RST = 16'd281;
    localparam logic [0:0]         REG_DET_FLOOR = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] lin0;
        logic signed [DATA_W-1:0] lin1;
        logic signed [DATA_W-1:0] lin2;
        logic signed [DATA_W-1:0] lin4;
        logic signed [DATA_W-1:0] lin5;
        logic signed [DATA_W-1:0] lin6;
        logic signed [DATA_W-1:0] lin8;
        logic signed [DATA_W-1:0] lin9;
        logic signed [DATA_W-1:0] lin10;
        logic signed [DATA_W-1:0] trans_x;
        logic signed [DATA_W-1:0] trans_y;
        logic signed [DATA_W-1:0] trans_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] inv0;
        logic signed [DATA_W-1:0] inv1;
        logic signed [DATA_W-1:0] inv2;
        logic signed [DATA_W-1:0] inv4;
        logic signed [DATA_W-1:0] inv5;
        logic signed [DATA_W-1:0] inv6;
        logic signed [DATA_W-1:0] inv8;
        logic signed [DATA_W-1:0] inv9;
        logic signed [DATA_W-1:0] inv10;
        logic signed [DATA_W-1:0] inv_tx;
        logic signed [DATA_W-1:0] inv_ty;
        logic signed [DATA_W-1:0] inv_tz;
    } t_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
        logic signed [DATA_W-1:0] tz;
    } t_trans;

    // quotient overflow and result sign per lane, plus the translation
    typedef struct packed {
        logic [LANES-1:0] big;
        logic [LANES-1:0] neg;
        t_trans           t;
    } t_side;

endpackage
`default_nettype wire

>>> rtl/core/ami_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ami_in_if
// Input channel: one matrix per beat.
// ----------------------------------------------------------------------------
interface ami_in_if;
    logic        valid;
    logic        ready;
    ami_pkg::t_in data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ami_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ami_out_if
// Output channel: one inverse per beat.
// ----------------------------------------------------------------------------
interface ami_out_if;
    logic          valid;
    logic          ready;
    ami_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ami_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ami_div_stage
// One restoring division step for all nine lanes: settles quotient bit BIT.
// ----------------------------------------------------------------------------
module ami_div_stage #(
    parameter int RW  = 131,
    parameter int BIT = 0
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_en,
    input  wire logic [RW-1:0]                             i_rem [0:ami_pkg::LANES-1],
    input  wire logic [ami_pkg::LANES-1:0][ami_pkg::DATA_W-1:0] i_q,
    input  wire logic [ami_pkg::D2_W-1:0]                  i_d2,
    input  wire ami_pkg::t_side                            i_side,
    output logic [RW-1:0]                                  o_rem [0:ami_pkg::LANES-1],
    output logic [ami_pkg::LANES-1:0][ami_pkg::DATA_W-1:0] o_q,
    output logic [ami_pkg::D2_W-1:0]                       o_d2,
    output ami_pkg::t_side                                 o_side
);

    logic [RW-1:0] dsh;
    assign dsh = RW'(i_d2) << BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ami_pkg::LANES; k++) begin
                if (i_rem[k] >= dsh) begin
                    o_rem[k]    <= i_rem[k] - dsh;
                    o_q[k]      <= i_q[k] | (ami_pkg::DATA_W'(1) << BIT);
                end else begin
                    o_rem[k]    <= i_rem[k];
                    o_q[k]      <= i_q[k];
                end
            end
            o_d2   <= i_d2;
            o_side <= i_side;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/affine_matrix_inverse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Fixed-point inverse of an affine 4x4 matrix: cofactors, exact determinant,
// floored determinant, 32-stage bit-per-cycle divider, rounded saturated
// quotients and inverse translation.
// Throughput one beat per cycle while the output is ready, set by the 45-stage
// pipeline whose divider settles one quotient bit per stage. Each stage holds
// while the next one is full and stalled.
// Reset (synchronous, active low) empties the pipeline and sets det_floor
// to 281.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ami_in_if.sink                             i_in,
    ami_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ami_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ami_pkg::PDATA_W-1:0]   pwdata,
    output logic [ami_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int NS   = 45;
    localparam int NDIV = 32;
    localparam int NW   = ((65 + 2*FRAC_BITS > 97) ? 65 + 2*FRAC_BITS : 97) + 1;
    localparam int RW   = (NW > ami_pkg::D2_W + 33) ? NW : ami_pkg::D2_W + 33;
    localparam int L    = ami_pkg::LANES;
    localparam int DW   = ami_pkg::DATA_W;

    // ---------------- configuration ----------------
    logic [ami_pkg::FLOOR_W-1:0] r_det_floor;
    logic [ami_pkg::FLOOR_W-1:0] floor_eff;
    logic                        reg_hit;

    assign reg_hit = (paddr[ami_pkg::PADDR_W-1] == ami_pkg::REG_DET_FLOOR);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? ami_pkg::PDATA_W'(r_det_floor) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_floor <= ami_pkg::DET_FLOOR_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_det_floor <= pwdata[ami_pkg::FLOOR_W-1:0];
        end
    end

    assign floor_eff = (r_det_floor == '0) ? ami_pkg::FLOOR_W'(1) : r_det_floor;

    // ---------------- flow control ----------------
    logic [NS-1:0] r_v;
    logic [NS:0]   stage_en;
    logic [NS-1:0] v_prev;

    assign stage_en[NS] = o_out.ready;
    assign v_prev[0]    = i_in.valid;

    for (genvar s = 0; s < NS; s++) begin : g_ctl
        assign stage_en[s] = !r_v[s] || stage_en[s+1];
        if (s > 0) begin : g_prev
            assign v_prev[s] = r_v[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (stage_en[s]) begin
                r_v[s] <= v_prev[s];
            end
        end
    end

    assign i_in.ready  = stage_en[0];
    assign o_out.valid = r_v[NS-1];

    // ---------------- stage 0: cofactor products ----------------
    logic signed [ami_pkg::PROD_W-1:0] r_p0 [0:2*L-1];
    logic signed [DW-1:0]              r_abc0 [0:2];
    ami_pkg::t_trans                   r_t0;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_p0[0]  <= i_in.data.lin5 * i_in.data.lin10;
            r_p0[1]  <= i_in.data.lin6 * i_in.data.lin9;
            r_p0[2]  <= i_in.data.lin2 * i_in.data.lin9;
            r_p0[3]  <= i_in.data.lin1 * i_in.data.lin10;
            r_p0[4]  <= i_in.data.lin1 * i_in.data.lin6;
            r_p0[5]  <= i_in.data.lin2 * i_in.data.lin5;
            r_p0[6]  <= i_in.data.lin6 * i_in.data.lin8;
            r_p0[7]  <= i_in.data.lin4 * i_in.data.lin10;
            r_p0[8]  <= i_in.data.lin0 * i_in.data.lin10;
            r_p0[9]  <= i_in.data.lin2 * i_in.data.lin8;
            r_p0[10] <= i_in.data.lin2 * i_in.data.lin4;
            r_p0[11] <= i_in.data.lin0 * i_in.data.lin6;
            r_p0[12] <= i_in.data.lin4 * i_in.data.lin9;
            r_p0[13] <= i_in.data.lin5 * i_in.data.lin8;
            r_p0[14] <= i_in.data.lin1 * i_in.data.lin8;
            r_p0[15] <= i_in.data.lin0 * i_in.data.lin9;
            r_p0[16] <= i_in.data.lin0 * i_in.data.lin5;
            r_p0[17] <= i_in.data.lin1 * i_in.data.lin4;
            r_abc0[0] <= i_in.data.lin0;
            r_abc0[1] <= i_in.data.lin1;
            r_abc0[2] <= i_in.data.lin2;
            r_t0.tx   <= i_in.data.trans_x;
            r_t0.ty   <= i_in.data.trans_y;
            r_t0.tz   <= i_in.data.trans_z;
        end
    end

    // ---------------- stage 1: cofactors ----------------
    logic signed [ami_pkg::COF_W-1:0] r_cof1 [0:L-1];
    logic signed [DW-1:0]             r_abc1 [0:2];
    ami_pkg::t_trans                  r_t1;

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            for (int k = 0; k < L; k++) begin
                r_cof1[k] <= ami_pkg::COF_W'(r_p0[2*k]) - ami_pkg::COF_W'(r_p0[2*k+1]);
            end
            r_abc1 <= r_abc0;
            r_t1   <= r_t0;
        end
    end

    // ---------------- stage 2: determinant partial products ----------------
    // det = a*cof0 + b*cof3 + c*cof6, each cofactor split at bit 32
    logic signed [ami_pkg::COF_W-1:0] r_ph2 [0:2];
    logic signed [ami_pkg::COF_W-1:0] r_pl2 [0:2];
    logic signed [ami_pkg::COF_W-1:0] r_cof2 [0:L-1];
    ami_pkg::t_trans                  r_t2;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            for (int j = 0; j < 3; j++) begin
                r_ph2[j] <= $signed(r_cof1[3*j][ami_pkg::COF_W-1:32]) * r_abc1[j];
                r_pl2[j] <= $signed({1'b0, r_cof1[3*j][31:0]}) * r_abc1[j];
            end
            r_cof2 <= r_cof1;
            r_t2   <= r_t1;
        end
    end

    // ---------------- stage 3: determinant terms ----------------
    logic signed [ami_pkg::DET_W-1:0] r_term3 [0:2];
    logic signed [ami_pkg::COF_W-1:0] r_cof3 [0:L-1];
    ami_pkg::t_trans                  r_t3;

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            for (int j = 0; j < 3; j++) begin
                r_term3[j] <= (ami_pkg::DET_W'(r_ph2[j]) <<< 32) + ami_pkg::DET_W'(r_pl2[j]);
            end
            r_cof3 <= r_cof2;
            r_t3   <= r_t2;
        end
    end

    // ---------------- stage 4: determinant ----------------
    logic signed [ami_pkg::DET_W-1:0] r_det4;
    logic signed [ami_pkg::COF_W-1:0] r_cof4 [0:L-1];
    ami_pkg::t_trans                  r_t4;

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_det4 <= r_term3[0] + r_term3[1] + r_term3[2];
            r_cof4 <= r_cof3;
            r_t4   <= r_t3;
        end
    end

    // ---------------- stage 5: magnitudes ----------------
    logic [ami_pkg::DMAG_W-1:0] r_dmag5;
    logic                       r_dneg5;
    logic [ami_pkg::CMAG_W-1:0] r_cmag5 [0:L-1];
    logic [L-1:0]               r_cneg5;
    ami_pkg::t_trans            r_t5;
    logic [ami_pkg::DET_W-1:0]  det_abs;
    logic [ami_pkg::COF_W-1:0]  cof_abs [0:L-1];

    always_comb begin
        det_abs = r_det4[ami_pkg::DET_W-1] ? -r_det4 : r_det4;
        for (int k = 0; k < L; k++) begin
            cof_abs[k] = r_cof4[k][ami_pkg::COF_W-1] ? -r_cof4[k] : r_cof4[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_dmag5 <= det_abs[ami_pkg::DMAG_W-1:0];
            r_dneg5 <= r_det4[ami_pkg::DET_W-1];
            for (int k = 0; k < L; k++) begin
                r_cmag5[k] <= cof_abs[k][ami_pkg::CMAG_W-1:0];
                r_cneg5[k] <= r_cof4[k][ami_pkg::COF_W-1];
            end
            r_t5 <= r_t4;
        end
    end

    // ---------------- stage 6: determinant floor ----------------
    logic [ami_pkg::DMAG_W-1:0] r_dmag6;
    logic [L-1:0]               r_neg6;
    logic [ami_pkg::CMAG_W-1:0] r_cmag6 [0:L-1];
    ami_pkg::t_trans            r_t6;
    logic                       det_small;

    assign det_small = (r_dmag5 < ami_pkg::DMAG_W'(floor_eff));

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r_dmag6 <= det_small ? ami_pkg::DMAG_W'(floor_eff) : r_dmag5;
            r_neg6  <= r_cneg5 ^ {L{r_dneg5 && !det_small}};
            r_cmag6 <= r_cmag5;
            r_t6    <= r_t5;
        end
    end

    // ---------------- stage 7: numerators, doubled divisor ----------------
    // q = (2*|cof|*2^2F + d) / (2*d)
    logic [NW-1:0]              r_n7 [0:L-1];
    logic [ami_pkg::D2_W-1:0]   r_d2_7;
    logic [L-1:0]               r_neg7;
    ami_pkg::t_trans            r_t7;

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            for (int k = 0; k < L; k++) begin
                r_n7[k] <= (NW'(r_cmag6[k]) << (2*FRAC_BITS + 1)) + NW'(r_dmag6);
            end
            r_d2_7 <= {r_dmag6, 1'b0};
            r_neg7 <= r_neg6;
            r_t7   <= r_t6;
        end
    end

    // ---------------- stage 8: overflow check, divider entry ----------------
    logic [RW-1:0]              div_rem [0:NDIV][0:L-1];
    logic [L-1:0][DW-1:0]       div_q   [0:NDIV];
    logic [ami_pkg::D2_W-1:0]   div_d2  [0:NDIV];
    ami_pkg::t_side             div_side[0:NDIV];
    logic [RW-1:0]              d2_top;

    assign d2_top    = RW'(r_d2_7) << DW;
    assign div_q[0]  = '0;

    always_ff @(posedge i_clk) begin
        if (stage_en[8]) begin
            for (int k = 0; k < L; k++) begin
                div_rem[0][k]      <= RW'(r_n7[k]);
                div_side[0].big[k] <= (RW'(r_n7[k]) >= d2_top);
            end
            div_d2[0]       <= r_d2_7;
            div_side[0].neg <= r_neg7;
            div_side[0].t   <= r_t7;
        end
    end

    // ---------------- stages 9..40: one quotient bit each ----------------
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        ami_div_stage #(
            .RW  (RW),
            .BIT (NDIV - 1 - j)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (stage_en[9+j]),
            .i_rem  (div_rem[j]),
            .i_q    (div_q[j]),
            .i_d2   (div_d2[j]),
            .i_side (div_side[j]),
            .o_rem  (div_rem[j+1]),
            .o_q    (div_q[j+1]),
            .o_d2   (div_d2[j+1]),
            .o_side (div_side[j+1])
        );
    end

    // ---------------- stage 41: quotient saturation ----------------
    logic signed [DW-1:0] r_inv41 [0:L-1];
    ami_pkg::t_trans      r_t41;
    logic signed [DW-1:0] inv_sat [0:L-1];

    always_comb begin
        for (int k = 0; k < L; k++) begin
            if (!div_side[NDIV].neg[k]) begin
                inv_sat[k] = (div_side[NDIV].big[k] || div_q[NDIV][k][DW-1])
                             ? 32'sh7FFFFFFF : $signed(div_q[NDIV][k]);
            end else begin
                inv_sat[k] = (div_side[NDIV].big[k] || (div_q[NDIV][k] > 32'h80000000))
                             ? 32'sh80000000 : $signed(-div_q[NDIV][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[41]) begin
            r_inv41 <= inv_sat;
            r_t41   <= div_side[NDIV].t;
        end
    end

    // ---------------- stage 42: translation products ----------------
    logic signed [ami_pkg::PROD_W-1:0] r_tp42 [0:L-1];
    logic signed [DW-1:0]              r_inv42 [0:L-1];

    always_ff @(posedge i_clk) begin
        if (stage_en[42]) begin
            for (int c = 0; c < 3; c++) begin
                r_tp42[3*c]   <= r_t41.tx * r_inv41[c];
                r_tp42[3*c+1] <= r_t41.ty * r_inv41[c+3];
                r_tp42[3*c+2] <= r_t41.tz * r_inv41[c+6];
            end
            r_inv42 <= r_inv41;
        end
    end

    // ---------------- stage 43: negated sums ----------------
    logic signed [ami_pkg::TSUM_W-1:0] r_u43 [0:2];
    logic signed [DW-1:0]              r_inv43 [0:L-1];

    always_ff @(posedge i_clk) begin
        if (stage_en[43]) begin
            for (int c = 0; c < 3; c++) begin
                r_u43[c] <= ami_pkg::TSUM_W'(0)
                            - (ami_pkg::TSUM_W'(r_tp42[3*c])
                               + ami_pkg::TSUM_W'(r_tp42[3*c+1])
                               + ami_pkg::TSUM_W'(r_tp42[3*c+2]));
            end
            r_inv43 <= r_inv42;
        end
    end

    // ---------------- stage 44: rounding, output register ----------------
    ami_pkg::t_out                     r_out;
    logic [ami_pkg::TSUM_W-1:0]        u_abs [0:2];
    logic [ami_pkg::TSUM_W-1:0]        u_rnd [0:2];
    logic signed [DW-1:0]              tr_sat [0:2];
    logic [ami_pkg::TSUM_W-1:0]        half;

    assign half = ami_pkg::TSUM_W'(1) << (FRAC_BITS - 1);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            u_abs[c] = r_u43[c][ami_pkg::TSUM_W-1] ? -r_u43[c] : r_u43[c];
            u_rnd[c] = (u_abs[c] + half) >> FRAC_BITS;
            if (!r_u43[c][ami_pkg::TSUM_W-1]) begin
                tr_sat[c] = (u_rnd[c] > ami_pkg::TSUM_W'(32'h7FFFFFFF))
                            ? 32'sh7FFFFFFF : $signed(u_rnd[c][DW-1:0]);
            end else begin
                tr_sat[c] = (u_rnd[c] > ami_pkg::TSUM_W'(32'h80000000))
                            ? 32'sh80000000 : $signed(-u_rnd[c][DW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[44]) begin
            r_out.inv0   <= r_inv43[0];
            r_out.inv1   <= r_inv43[1];
            r_out.inv2   <= r_inv43[2];
            r_out.inv4   <= r_inv43[3];
            r_out.inv5   <= r_inv43[4];
            r_out.inv6   <= r_inv43[5];
            r_out.inv8   <= r_inv43[6];
            r_out.inv9   <= r_inv43[7];
            r_out.inv10  <= r_inv43[8];
            r_out.inv_tx <= tr_sat[0];
            r_out.inv_ty <= tr_sat[1];
            r_out.inv_tz <= tr_sat[2];
        end
    end

    assign o_out.data = r_out;

endmodule
`default_nettype wire

>>> test/affine_matrix_inverse_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_test
// Drives matrices into the inverse pipeline under random gaps and back
// pressure, predicts every inverse in exact wide arithmetic and compares each
// output beat field by field. Runs several det_floor settings, extremes too.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_test;

    localparam int FRAC    = 16;
    localparam int LAT     = 45;
    localparam int IDLE_LIM = 3000;
    localparam int HOLD_LEN = 600;

    // expected inverses, oldest first
    class inverse_board;
        ami_pkg::t_out inv_q[$];
        int   errors;

        function automatic logic [31:0] sat_q(bit neg, logic [127:0] mag);
            if (!neg) return (mag > 128'h7fffffff) ? 32'h7fffffff : mag[31:0];
            if (mag > 128'h80000000) return 32'h80000000;
            return -mag[31:0];
        endfunction

        function automatic logic [127:0] mag_of(logic signed [127:0] v);
            return v[127] ? -v : v;
        endfunction

        function automatic logic [31:0] div_round(logic signed [127:0] cof,
                                                 logic signed [127:0] det);
            logic [127:0] n, d, q;
            n = mag_of(cof) << (2 * FRAC);
            d = mag_of(det);
            q = ((n << 1) + d) / (d << 1);
            return sat_q(cof[127] ^ det[127], q);
        endfunction

        function automatic logic [31:0] move_back(logic signed [127:0] tx,
                                                 logic signed [127:0] ty,
                                                 logic signed [127:0] tz,
                                                 logic signed [31:0] r0,
                                                 logic signed [31:0] r1,
                                                 logic signed [31:0] r2);
            logic signed [127:0] s, w0, w1, w2;
            w0 = r0;
            w1 = r1;
            w2 = r2;
            s = -(tx * w0 + ty * w1 + tz * w2);
            return sat_q(s[127], (mag_of(s) + (128'd1 << (FRAC - 1))) >> FRAC);
        endfunction

        function void note_matrix(ami_pkg::t_in m, logic [15:0] floor_val);
            logic signed [127:0] a, b, c, d, e, f, g, h, i, det;
            logic signed [127:0] tx, ty, tz;
            logic signed [127:0] cof[9];
            logic [31:0] r[9];
            logic [127:0] fl;
            ami_pkg::t_out o;
            a = m.lin0; b = m.lin1; c = m.lin2;
            d = m.lin4; e = m.lin5; f = m.lin6;
            g = m.lin8; h = m.lin9; i = m.lin10;
            tx = m.trans_x; ty = m.trans_y; tz = m.trans_z;
            fl = (floor_val == 0) ? 128'd1 : 128'(floor_val);
            det = a*e*i - a*f*h - b*d*i + b*f*g + c*d*h - c*e*g;
            if (mag_of(det) < fl) det = fl;
            cof[0] = e*i - f*h; cof[1] = c*h - b*i; cof[2] = b*f - c*e;
            cof[3] = f*g - d*i; cof[4] = a*i - c*g; cof[5] = c*d - a*f;
            cof[6] = d*h - e*g; cof[7] = b*g - a*h; cof[8] = a*e - b*d;
            for (int k = 0; k < 9; k++) r[k] = div_round(cof[k], det);
            o.inv0 = r[0]; o.inv1 = r[1]; o.inv2 = r[2];
            o.inv4 = r[3]; o.inv5 = r[4]; o.inv6 = r[5];
            o.inv8 = r[6]; o.inv9 = r[7]; o.inv10 = r[8];
            o.inv_tx = move_back(tx, ty, tz, r[0], r[3], r[6]);
            o.inv_ty = move_back(tx, ty, tz, r[1], r[4], r[7]);
            o.inv_tz = move_back(tx, ty, tz, r[2], r[5], r[8]);
            inv_q.push_back(o);
        endfunction

        function void check_inverse(ami_pkg::t_out got);
            string names[12] = '{"inv0", "inv1", "inv2", "inv4", "inv5", "inv6",
                                 "inv8", "inv9", "inv10", "inv_tx", "inv_ty",
                                 "inv_tz"};
            ami_pkg::t_out want;
            logic [31:0] w, g;
            if (inv_q.size() == 0) begin
                $error("output beat with nothing expected");
                errors++;
                return;
            end
            want = inv_q.pop_front();
            for (int k = 0; k < 12; k++) begin
                w = want[(11-k)*32 +: 32];
                g = got[(11-k)*32 +: 32];
                if (w !== g) begin
                    $error("%s: expected %0d, got %0d", names[k], $signed(w),
                           $signed(g));
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ami_pkg::PADDR_W-1:0] paddr;
    logic [ami_pkg::PDATA_W-1:0] pwdata;
    logic [ami_pkg::PDATA_W-1:0] prdata;
    logic pready;

    ami_in_if  in_ch ();
    ami_out_if out_ch ();

    affine_matrix_inverse u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    inverse_board board = new();
    logic [15:0]  floor_now = ami_pkg::DET_FLOOR_RST;
    bit           calm = 0;
    bit           hold_pending = 0;
    int           idle_cycles = 0;

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) board.check_inverse(out_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIM) begin
            $display("affine_matrix_inverse_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, one long hold-off when asked
    initial begin
        int gap;
        out_ch.ready = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 13);
            if (hold_pending) begin
                gap = HOLD_LEN;
                hold_pending = 0;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                out_ch.ready <= 0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready <= 1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic write_floor(logic [15:0] v);
        @(negedge i_clk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= ami_pkg::PADDR_W'(4 * ami_pkg::REG_DET_FLOOR);
        pwdata  <= ami_pkg::PDATA_W'(v);
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        floor_now = v;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // sender is parked at a falling edge between beats
    task automatic send_matrix(ami_pkg::t_in m);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data  <= m;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_matrix(m, floor_now);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (board.inv_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic ami_pkg::t_in diag(logic [31:0] s, logic [31:0] t);
        ami_pkg::t_in m;
        m = '0;
        m.lin0 = s; m.lin5 = s; m.lin10 = s;
        m.trans_x = t; m.trans_y = -t; m.trans_z = t;
        return m;
    endfunction

    function automatic logic signed [31:0] near_unit();
        return $urandom_range(0, 262143) - 131072;
    endfunction

    function automatic ami_pkg::t_in random_matrix();
        ami_pkg::t_in m;
        int kind;
        kind = $urandom_range(0, 9);
        m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (kind < 5) begin
            m.lin0 = near_unit(); m.lin1 = near_unit(); m.lin2 = near_unit();
            m.lin4 = near_unit(); m.lin5 = near_unit(); m.lin6 = near_unit();
            m.lin8 = near_unit(); m.lin9 = near_unit(); m.lin10 = near_unit();
            if (kind < 2) begin
                m.trans_x = near_unit() <<< 4;
                m.trans_y = near_unit() <<< 4;
                m.trans_z = near_unit() <<< 4;
            end
        end else if (kind < 7) begin
            m.lin0 = 32'sd65536 + (near_unit() >>> 4);
            m.lin5 = 32'sd65536 + (near_unit() >>> 4);
            m.lin10 = -32'sd65536 + (near_unit() >>> 4);
            m.lin1 = near_unit() >>> 3; m.lin2 = near_unit() >>> 3;
            m.lin4 = near_unit() >>> 3; m.lin6 = near_unit() >>> 3;
            m.lin8 = near_unit() >>> 3; m.lin9 = near_unit() >>> 3;
        end else if (kind == 7) begin
            m.lin0 = $urandom_range(0, 600) - 300; m.lin1 = $urandom_range(0, 600) - 300;
            m.lin2 = $urandom_range(0, 600) - 300; m.lin4 = $urandom_range(0, 600) - 300;
            m.lin5 = $urandom_range(0, 600) - 300; m.lin6 = $urandom_range(0, 600) - 300;
            m.lin8 = $urandom_range(0, 600) - 300; m.lin9 = $urandom_range(0, 600) - 300;
            m.lin10 = $urandom_range(0, 600) - 300;
        end
        return m;
    endfunction

    task automatic directed_set();
        ami_pkg::t_in m;
        send_matrix(diag(32'sd65536, 32'sd0));
        send_matrix(diag(32'sd65536, 32'sh7fffffff));
        send_matrix(diag(32'sd131072, 32'sh80000000));
        send_matrix(diag(-32'sd32768, 32'sd12345678));
        send_matrix(diag(32'sd0, 32'sd65536));
        send_matrix(diag(32'sd1, 32'sd1));
        send_matrix(diag(32'sd3, -32'sd5));
        send_matrix(diag(32'sh7fffffff, 32'sh7fffffff));
        send_matrix(diag(32'sh80000000, 32'sh80000000));
        send_matrix(diag(32'sd2, 32'sh40000000));
        m = {12{32'hffffffff}};
        send_matrix(m);
        m = {12{32'h80000000}};
        send_matrix(m);
        m = {12{32'h7fffffff}};
        send_matrix(m);
        m = {32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000,
             32'h1, 32'h0, 32'h1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h1};
        send_matrix(m);
        m = diag(32'sd65536, 32'sd0);
        m.lin1 = 32'sd65536;
        m.lin4 = 32'sd65536;
        send_matrix(m);
        m = diag(32'sd256, 32'sd1000);
        m.lin10 = 32'sd65536;
        send_matrix(m);
        m = diag(32'sd65536, 32'sd0);
        m.lin0 = 32'sd1;
        send_matrix(m);
        m = '0;
        m.lin1 = 32'sd65536; m.lin6 = 32'sd65536; m.lin8 = 32'sd65536;
        m.trans_x = 32'sd7; m.trans_y = -32'sd9; m.trans_z = 32'sd32768;
        send_matrix(m);
    endtask

    initial begin
        logic [15:0] floors[6];
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        directed_set();
        drain();

        floors = '{16'd65535, 16'd1, 16'd0, 16'd281, 16'd4096, 16'($urandom)};
        for (int p = 0; p < 6; p++) begin
            write_floor(floors[p]);
            if (p == 0) directed_set();
            calm = (p == 3);
            if (p == 1) hold_pending = 1;
            for (int n = 0; n < 265; n++) send_matrix(random_matrix());
            calm = 0;
            drain();
        end

        repeat (LAT + 20) @(posedge i_clk);
        if (board.errors == 0 && board.inv_q.size() == 0) begin
            $display("affine_matrix_inverse_test: done, clean");
        end else begin
            $display("affine_matrix_inverse_test: done, errors");
        end
        $finish;
    end

endmodule
